// File: sv/avr_pkg.sv
// ============================================================================
// avr_pkg: shared definitions for the axis-angle vector rotator
// Holds the format constants, the CORDIC arctangent table and the item
// types that travel between the pipeline sections.
// ============================================================================
`default_nettype none

package avr_pkg;

    // Field formats.
    localparam int COMPONENT_BITS = 24;
    localparam int ANGLE_BITS     = 16;
    localparam int AXIS_BITS      = 16;

    // Stream packing, rounded up to whole bytes.
    localparam int IN_FIELD_BITS  = 3 * COMPONENT_BITS + 3 * AXIS_BITS + ANGLE_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * COMPONENT_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // CORDIC datapath.
    localparam int CORDIC_STEPS = 30;
    localparam int CORDIC_W     = 34;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 34'sd652032874;

    // Matrix datapath widths.
    localparam int K_W   = CORDIC_W + 1;
    localparam int AA_W  = 2 * AXIS_BITS;
    localparam int KAA_W = K_W + AA_W;
    localparam int SA_W  = CORDIC_W + AXIS_BITS;
    localparam int M_W   = 32;
    localparam int MV_W  = M_W + COMPONENT_BITS;
    localparam int ACC_W = MV_W + 2;
    localparam int RES_W = ACC_W - 24;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
    };

    // Vector and axis, carried alongside the angle through the CORDIC.
    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] vec_x;
        logic signed [COMPONENT_BITS-1:0] vec_y;
        logic signed [COMPONENT_BITS-1:0] vec_z;
        logic signed [AXIS_BITS-1:0]      axis_x;
        logic signed [AXIS_BITS-1:0]      axis_y;
        logic signed [AXIS_BITS-1:0]      axis_z;
    } avr_side_t;

endpackage

`default_nettype wire

// File: sv/avr_cordic.sv
// ============================================================================
// avr_cordic: pipelined sine and cosine
// One register stage for the quadrant fold, then one stage per CORDIC
// iteration. The vector and axis ride along with each item.
// ============================================================================
`default_nettype none

module avr_cordic (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic [avr_pkg::ANGLE_BITS-1:0]     in_angle,
    input  wire avr_pkg::avr_side_t                 in_side,
    output logic                                    out_valid,
    output logic                                    out_flip,
    output logic signed [avr_pkg::CORDIC_W-1:0]     out_x,
    output logic signed [avr_pkg::CORDIC_W-1:0]     out_y,
    output avr_pkg::avr_side_t                      out_side
);
    import avr_pkg::*;

    logic                       valid_reg [CORDIC_STEPS+1];
    logic                       flip_reg  [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] x_reg     [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] y_reg     [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] z_reg     [CORDIC_STEPS+1];
    avr_side_t                  side_reg  [CORDIC_STEPS+1];

    logic signed [CORDIC_W-1:0] x_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] y_next [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] z_next [CORDIC_STEPS];

    logic [31:0] angle_full;
    logic [31:0] angle_fold;
    logic        flip_in;

    // Quadrant fold: the second and third quadrants are turned by a half turn.
    always_comb
    begin
        angle_full = {in_angle, {(32 - ANGLE_BITS){1'b0}}};
        flip_in    = (angle_full[31:30] == 2'b01) || (angle_full[31:30] == 2'b10);
        angle_fold = flip_in ? (angle_full + 32'h8000_0000) : angle_full;
    end

    // One micro-rotation per stage; the shift is fixed by the stage index.
    always_comb
    begin
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (!z_reg[i][CORDIC_W-1])
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - $signed({2'b00, ATAN_TURNS[i]});
            end
            else
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + $signed({2'b00, ATAN_TURNS[i]});
            end
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= CORDIC_STEPS; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flip_reg[0] <= flip_in;
            x_reg[0]    <= CORDIC_X0;
            y_reg[0]    <= '0;
            z_reg[0]    <= CORDIC_W'($signed(angle_fold));
            side_reg[0] <= in_side;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                flip_reg[i+1] <= flip_reg[i];
                x_reg[i+1]    <= x_next[i];
                y_reg[i+1]    <= y_next[i];
                z_reg[i+1]    <= z_next[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS];
    assign out_flip  = flip_reg[CORDIC_STEPS];
    assign out_x     = x_reg[CORDIC_STEPS];
    assign out_y     = y_reg[CORDIC_STEPS];
    assign out_side  = side_reg[CORDIC_STEPS];

endmodule

`default_nettype wire

// File: sv/avr_matrix.sv
// ============================================================================
// avr_matrix: Rodrigues matrix build and matrix-vector product
// Five register stages: axis products, scaled products, matrix entries,
// entry-component products, and the rounded and saturated sums.
// ============================================================================
`default_nettype none

module avr_matrix (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               en,
    input  wire logic                               in_valid,
    input  wire logic                               in_flip,
    input  wire logic signed [avr_pkg::CORDIC_W-1:0] in_x,
    input  wire logic signed [avr_pkg::CORDIC_W-1:0] in_y,
    input  wire avr_pkg::avr_side_t                 in_side,
    output logic                                    out_valid,
    output logic signed [avr_pkg::COMPONENT_BITS-1:0] rot_x,
    output logic signed [avr_pkg::COMPONENT_BITS-1:0] rot_y,
    output logic signed [avr_pkg::COMPONENT_BITS-1:0] rot_z
);
    import avr_pkg::*;

    localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< (COMPONENT_BITS - 1)) - 1);
    localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-(64'sd1 <<< (COMPONENT_BITS - 1)));

    logic [4:0] valid_reg;

    // Stage 1: sine, cosine, k = 1 - c, rounded cosine, axis products.
    logic signed [CORDIC_W-1:0] c1_next, s1_reg;
    logic signed [K_W-1:0]      k1_reg;
    logic signed [M_W-1:0]      ct1_reg;
    logic signed [AA_W-1:0]     aa1_reg [6];
    avr_side_t                  side1_reg;

    // Stage 2: raw products.
    logic signed [KAA_W-1:0]    kaa2_reg [6];
    logic signed [SA_W-1:0]     sa2_reg  [3];
    logic signed [M_W-1:0]      ct2_reg;
    avr_side_t                  side2_reg;

    // Stage 3: matrix entries.
    logic signed [M_W-1:0]      kr3 [6];
    logic signed [M_W-1:0]      sr3 [3];
    logic signed [M_W-1:0]      m3_reg [9];
    avr_side_t                  side3_reg;

    // Stage 4: entry-component products.
    logic signed [MV_W-1:0]     mv4_reg [9];

    // Stage 5: sums, rounding, saturation.
    logic signed [ACC_W-1:0]    acc5 [3];
    logic signed [RES_W-1:0]    res5 [3];
    logic signed [COMPONENT_BITS-1:0] rot_reg [3];

    assign c1_next = in_flip ? -in_x : in_x;

    // Rounded products and entry assembly; axis product order is xx yy zz xy xz yz.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            kr3[i] = M_W'((kaa2_reg[i] + (KAA_W'(1) <<< 33)) >>> 34);
        end
        for (int i = 0; i < 3; i++)
        begin
            sr3[i] = M_W'((sa2_reg[i] + (SA_W'(1) <<< 19)) >>> 20);
        end
    end

    // Row sums and round half up; saturation follows in stage 5.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc5[r] = ACC_W'(mv4_reg[3*r]) + ACC_W'(mv4_reg[3*r+1]) + ACC_W'(mv4_reg[3*r+2]);
            res5[r] = RES_W'((acc5[r] + (ACC_W'(1) <<< 23)) >>> 24);
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1.
            s1_reg     <= in_flip ? -in_y : in_y;
            k1_reg     <= (K_W'(1) <<< 30) - K_W'(c1_next);
            ct1_reg    <= M_W'((c1_next + CORDIC_W'(32)) >>> 6);
            aa1_reg[0] <= in_side.axis_x * in_side.axis_x;
            aa1_reg[1] <= in_side.axis_y * in_side.axis_y;
            aa1_reg[2] <= in_side.axis_z * in_side.axis_z;
            aa1_reg[3] <= in_side.axis_x * in_side.axis_y;
            aa1_reg[4] <= in_side.axis_x * in_side.axis_z;
            aa1_reg[5] <= in_side.axis_y * in_side.axis_z;
            side1_reg  <= in_side;

            // Stage 2.
            for (int i = 0; i < 6; i++)
            begin
                kaa2_reg[i] <= KAA_W'(k1_reg) * KAA_W'(aa1_reg[i]);
            end
            sa2_reg[0] <= SA_W'(s1_reg) * SA_W'(side1_reg.axis_x);
            sa2_reg[1] <= SA_W'(s1_reg) * SA_W'(side1_reg.axis_y);
            sa2_reg[2] <= SA_W'(s1_reg) * SA_W'(side1_reg.axis_z);
            ct2_reg    <= ct1_reg;
            side2_reg  <= side1_reg;

            // Stage 3.
            m3_reg[0] <= kr3[0] + ct2_reg;
            m3_reg[1] <= kr3[3] - sr3[2];
            m3_reg[2] <= kr3[4] + sr3[1];
            m3_reg[3] <= kr3[3] + sr3[2];
            m3_reg[4] <= kr3[1] + ct2_reg;
            m3_reg[5] <= kr3[5] - sr3[0];
            m3_reg[6] <= kr3[4] - sr3[1];
            m3_reg[7] <= kr3[5] + sr3[0];
            m3_reg[8] <= kr3[2] + ct2_reg;
            side3_reg <= side2_reg;

            // Stage 4.
            for (int r = 0; r < 3; r++)
            begin
                mv4_reg[3*r]   <= MV_W'(m3_reg[3*r])   * MV_W'(side3_reg.vec_x);
                mv4_reg[3*r+1] <= MV_W'(m3_reg[3*r+1]) * MV_W'(side3_reg.vec_y);
                mv4_reg[3*r+2] <= MV_W'(m3_reg[3*r+2]) * MV_W'(side3_reg.vec_z);
            end

            // Stage 5.
            for (int r = 0; r < 3; r++)
            begin
                if (res5[r] > SAT_HI)
                begin
                    rot_reg[r] <= COMPONENT_BITS'(SAT_HI);
                end
                else if (res5[r] < SAT_LO)
                begin
                    rot_reg[r] <= COMPONENT_BITS'(SAT_LO);
                end
                else
                begin
                    rot_reg[r] <= COMPONENT_BITS'(res5[r]);
                end
            end
        end
    end

    assign out_valid = valid_reg[4];
    assign rot_x     = rot_reg[0];
    assign rot_y     = rot_reg[1];
    assign rot_z     = rot_reg[2];

endmodule

`default_nettype wire

// File: sv/axis_angle_vector_rotate.sv
// ============================================================================
// axis_angle_vector_rotate: stream rotation of a vector about an axis
// Rodrigues rotation with a pipelined CORDIC for sine and cosine.
// ============================================================================
// Each input item (a Q7.16 vector, a Q1.14 axis and a binary angle) yields one
// output item with the rotated, saturated vector. The block takes one item per
// clock while the pipeline advances; each item passes one fold stage and 30 CORDIC
// iteration stages, then five matrix stages ending in the output register. The whole
// pipeline advances together; it holds while an output item waits and the
// sink is not ready, and then s_tready is low.
`default_nettype none

module axis_angle_vector_rotate (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, turn_angle (lowest first)
    input  wire logic [avr_pkg::IN_DATA_BITS-1:0]  s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // rot_x, rot_y, rot_z (lowest first)
    output logic [avr_pkg::OUT_DATA_BITS-1:0]      m_tdata
);
    import avr_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int AB = AXIS_BITS;

    logic                       en;
    avr_side_t                  in_side;
    logic [ANGLE_BITS-1:0]      in_angle;
    logic                       cor_valid;
    logic                       cor_flip;
    logic signed [CORDIC_W-1:0] cor_x;
    logic signed [CORDIC_W-1:0] cor_y;
    avr_side_t                  cor_side;
    logic signed [CB-1:0]       rot_x;
    logic signed [CB-1:0]       rot_y;
    logic signed [CB-1:0]       rot_z;

    // The pipeline moves unless a finished item is held at the output.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Unpack the input item.
    always_comb
    begin
        in_side.vec_x  = s_tdata[CB-1:0];
        in_side.vec_y  = s_tdata[2*CB-1:CB];
        in_side.vec_z  = s_tdata[3*CB-1:2*CB];
        in_side.axis_x = s_tdata[3*CB+AB-1:3*CB];
        in_side.axis_y = s_tdata[3*CB+2*AB-1:3*CB+AB];
        in_side.axis_z = s_tdata[3*CB+3*AB-1:3*CB+2*AB];
        in_angle       = s_tdata[IN_FIELD_BITS-1:3*CB+3*AB];
    end

    avr_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_angle  (in_angle),
        .in_side   (in_side),
        .out_valid (cor_valid),
        .out_flip  (cor_flip),
        .out_x     (cor_x),
        .out_y     (cor_y),
        .out_side  (cor_side)
    );

    avr_matrix u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cor_valid),
        .in_flip   (cor_flip),
        .in_x      (cor_x),
        .in_y      (cor_y),
        .in_side   (cor_side),
        .out_valid (m_tvalid),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z)
    );

    // Pack the output item.
    assign m_tdata = OUT_DATA_BITS'({rot_z, rot_y, rot_x});

endmodule

`default_nettype wire
